FILE: hw/rtl/fst_pkg.sv
package fst_pkg;

  // item fields
  localparam int unsigned STEP_BITS   = 15;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned SINE_BITS   = 15;
  localparam int unsigned FADE_BITS   = 8;
  localparam int unsigned ENV_BITS    = 16;
  localparam int unsigned GAIN_BITS   = 15;

  // fade length is min(total / 8, rate / 100)
  localparam int unsigned RATE_HZ    = 16000;
  localparam int unsigned FADE_CAP   = RATE_HZ / 100;
  localparam int unsigned FADE_SHIFT = 3;

  // 0.6 of full scale 32000
  localparam int unsigned TONE_GAIN = 19200;

  // queue depths (powers of two)
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 4;

  // sine table build, q30 taylor series
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  // classified item handed from the front part to the back part
  typedef struct packed {
    logic                 past_end;
    logic                 unity;
    logic                 neg;
    logic [SINE_BITS-1:0] sine;
    logic [FADE_BITS-1:0] num;
    logic [FADE_BITS-1:0] fade;
  } fst_item_t;

  // entry k of a quarter-wave table with 2^qbits steps, rounded q1.15
  function automatic logic [SINE_BITS-1:0] quarter_sine(input int unsigned k,
                                                        input int unsigned qbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    int              i;
    x    = (HALF_PI_Q30 * 64'(k)) >> qbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (i = 0; i < 8; i++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[i];
      if ((i & 1) == 0) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    sum = (sum + 64'd16384) >> 15;
    if (sum > 64'd32767) begin
      sum = 64'd32767;
    end
    return sum[SINE_BITS-1:0];
  endfunction

endpackage

FILE: hw/rtl/fst_fifo.sv
module fst_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: hw/rtl/fst_front.sv
module fst_front #(
  parameter int FRAME_BITS      = 20,
  parameter int PHASE_BITS      = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [FRAME_BITS-1:0]   frame_index,
  input  logic [FRAME_BITS-1:0]   total_frames,
  input  logic [fst_pkg::STEP_BITS-1:0] tone_step,
  output logic                    item_push,
  output fst_pkg::fst_item_t      item,
  input  logic                    item_full
);

  import fst_pkg::*;

  localparam int WIDE_BITS    = (FRAME_BITS > PHASE_BITS) ? FRAME_BITS : PHASE_BITS;
  localparam int PROD_BITS    = PHASE_BITS + STEP_BITS;
  localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;
  localparam int QUARTER_LEN  = 1 << QUARTER_BITS;
  localparam int ADDR_BITS    = SINE_TABLE_BITS - 1;
  localparam int SHORT_BITS   = FRAME_BITS - FADE_SHIFT;
  localparam int EXT_BITS     = PHASE_BITS + SINE_TABLE_BITS;

  // quarter-wave table, built at elaboration
  logic [SINE_BITS-1:0] rom_w [QUARTER_LEN+1];

  for (genvar k = 0; k <= QUARTER_LEN; k++) begin : g_rom
    localparam logic [SINE_BITS-1:0] ENTRY = quarter_sine(k, QUARTER_BITS);
    assign rom_w[k] = ENTRY;
  end

  logic stage_en;
  logic take;

  // stage 0: phase product, distance to end, fade length
  logic                    v0_r;
  logic                    pe0_r, pe0_nxt;
  logic [FRAME_BITS-1:0]   diff0_r, diff0_nxt;
  logic [FRAME_BITS-1:0]   frame0_r;
  logic [FADE_BITS-1:0]    fade0_r, fade0_nxt;
  logic [PHASE_BITS-1:0]   phase0_r, phase0_nxt;
  logic [FRAME_BITS:0]     diff_ext;
  logic [SHORT_BITS-1:0]   short_len;
  logic [WIDE_BITS-1:0]    frame_wide;
  logic [PROD_BITS-1:0]    phase_prod;

  // stage 1: ramp classification, table address
  logic                    v1_r;
  logic                    pe1_r;
  logic                    unity1_r, unity1_nxt;
  logic                    neg1_r, neg1_nxt;
  logic [FADE_BITS-1:0]    num1_r, num1_nxt;
  logic [FADE_BITS-1:0]    fade1_r;
  logic [ADDR_BITS-1:0]    addr1_r, addr1_nxt;
  logic                    ramp_down;
  logic                    ramp_up;
  logic [EXT_BITS-1:0]     idx_ext;
  logic [SINE_TABLE_BITS-1:0] idx;

  // stage 2: table read, item ready for the queue
  logic                    v2_r;
  fst_item_t               item_r, item_nxt;

  assign stage_en  = !(v2_r && item_full);
  assign in_full   = !stage_en;
  assign take      = in_push && stage_en;
  assign item_push = v2_r && !item_full;
  assign item      = item_r;

  always_comb begin
    diff_ext   = {1'b0, total_frames} - {1'b0, frame_index};
    pe0_nxt    = diff_ext[FRAME_BITS] || (diff_ext[FRAME_BITS-1:0] == '0);
    diff0_nxt  = diff_ext[FRAME_BITS-1:0];
    short_len  = total_frames[FRAME_BITS-1:FADE_SHIFT];
    fade0_nxt  = (short_len > SHORT_BITS'(FADE_CAP)) ? FADE_BITS'(FADE_CAP)
                                                     : short_len[FADE_BITS-1:0];
    frame_wide = WIDE_BITS'(frame_index);
    phase_prod = PROD_BITS'(frame_wide[PHASE_BITS-1:0]) * PROD_BITS'(tone_step);
    phase0_nxt = phase_prod[PHASE_BITS-1:0];
  end

  always_comb begin
    // falling edge wins over rising when both apply
    ramp_down  = diff0_r < FRAME_BITS'(fade0_r);
    ramp_up    = frame0_r < FRAME_BITS'(fade0_r);
    num1_nxt   = ramp_down ? diff0_r[FADE_BITS-1:0] : frame0_r[FADE_BITS-1:0];
    unity1_nxt = !(ramp_down || ramp_up);
    idx_ext    = {phase0_r, {SINE_TABLE_BITS{1'b0}}};
    idx        = idx_ext[EXT_BITS-1 -: SINE_TABLE_BITS];
    neg1_nxt   = idx[SINE_TABLE_BITS-1];
    addr1_nxt  = idx[QUARTER_BITS] ?
                 ADDR_BITS'(QUARTER_LEN) - ADDR_BITS'(idx[QUARTER_BITS-1:0]) :
                 ADDR_BITS'(idx[QUARTER_BITS-1:0]);
  end

  always_comb begin
    item_nxt.past_end = pe1_r;
    item_nxt.unity    = unity1_r;
    item_nxt.neg      = neg1_r;
    item_nxt.sine     = rom_w[addr1_r];
    item_nxt.num      = num1_r;
    item_nxt.fade     = fade1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (stage_en) begin
      v0_r <= take;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      pe0_r    <= pe0_nxt;
      diff0_r  <= diff0_nxt;
      frame0_r <= frame_index;
      fade0_r  <= fade0_nxt;
      phase0_r <= phase0_nxt;
      pe1_r    <= pe0_r;
      unity1_r <= unity1_nxt;
      neg1_r   <= neg1_nxt;
      num1_r   <= num1_nxt;
      fade1_r  <= fade0_r;
      addr1_r  <= addr1_nxt;
      item_r   <= item_nxt;
    end
  end

endmodule

FILE: hw/rtl/fst_back.sv
module fst_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_empty,
  output logic                      item_pop,
  input  fst_pkg::fst_item_t        item,
  output logic                      out_push,
  output logic [fst_pkg::SAMPLE_BITS-1:0] out_data,
  input  logic                      out_full
);

  import fst_pkg::*;

  localparam int DIV_STEPS  = ENV_BITS;
  localparam int MAG_BITS   = SINE_BITS + GAIN_BITS;
  localparam int PROD_BITS  = MAG_BITS + ENV_BITS;
  localparam int RES_BITS   = SAMPLE_BITS - 1;
  localparam int LAST       = DIV_STEPS + 1;

  typedef struct packed {
    logic                 past_end;
    logic                 unity;
    logic                 neg;
    logic [SINE_BITS-1:0] sine;
    logic [MAG_BITS-1:0]  mag;
    logic [FADE_BITS-1:0] rem;
    logic [FADE_BITS-1:0] fade;
    logic [ENV_BITS-1:0]  quot;
  } div_stage_t;

  typedef struct packed {
    logic                 past_end;
    logic                 unity;
    logic                 neg;
    logic [MAG_BITS-1:0]  mag;
    logic [PROD_BITS-1:0] prod;
  } fin_stage_t;

  logic                 back_en;
  logic [LAST:0]        vld_r, vld_nxt;
  div_stage_t           st_r   [DIV_STEPS+1];
  div_stage_t           st_nxt [DIV_STEPS+1];
  fin_stage_t           fin_r, fin_nxt;
  logic [RES_BITS-1:0]  mag_out;

  assign back_en  = !(vld_r[LAST] && out_full);
  assign item_pop = !item_empty && back_en;
  assign out_push = vld_r[LAST] && !out_full;
  assign vld_nxt  = {vld_r[LAST-1:0], item_pop};

  // restoring divider, one quotient bit a stage; gain product rides along
  always_comb begin
    logic [FADE_BITS:0] rem2;
    st_nxt[0].past_end = item.past_end;
    st_nxt[0].unity    = item.unity;
    st_nxt[0].neg      = item.neg;
    st_nxt[0].sine     = item.sine;
    st_nxt[0].mag      = '0;
    st_nxt[0].rem      = item.num;
    st_nxt[0].fade     = item.fade;
    st_nxt[0].quot     = '0;
    for (int i = 1; i <= DIV_STEPS; i++) begin
      st_nxt[i] = st_r[i-1];
      rem2      = {st_r[i-1].rem, 1'b0};
      if (rem2 >= {1'b0, st_r[i-1].fade}) begin
        st_nxt[i].rem  = FADE_BITS'(rem2 - {1'b0, st_r[i-1].fade});
        st_nxt[i].quot = {st_r[i-1].quot[ENV_BITS-2:0], 1'b1};
      end else begin
        st_nxt[i].rem  = rem2[FADE_BITS-1:0];
        st_nxt[i].quot = {st_r[i-1].quot[ENV_BITS-2:0], 1'b0};
      end
    end
    st_nxt[1].mag = MAG_BITS'(st_r[0].sine) * MAG_BITS'(TONE_GAIN);
  end

  always_comb begin
    fin_nxt.past_end = st_r[DIV_STEPS].past_end;
    fin_nxt.unity    = st_r[DIV_STEPS].unity;
    fin_nxt.neg      = st_r[DIV_STEPS].neg;
    fin_nxt.mag      = st_r[DIV_STEPS].mag;
    fin_nxt.prod     = PROD_BITS'(st_r[DIV_STEPS].mag) * PROD_BITS'(st_r[DIV_STEPS].quot);
  end

  // magnitude truncates, sign goes on afterwards
  always_comb begin
    mag_out = fin_r.unity ? fin_r.mag[MAG_BITS-1:SINE_BITS]
                          : fin_r.prod[PROD_BITS-1:SINE_BITS+ENV_BITS];
    if (fin_r.past_end) begin
      out_data = '0;
    end else if (fin_r.neg) begin
      out_data = SAMPLE_BITS'(0) - {1'b0, mag_out};
    end else begin
      out_data = {1'b0, mag_out};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (back_en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
        st_r[i] <= st_nxt[i];
      end
      fin_r <= fin_nxt;
    end
  end

endmodule

FILE: hw/rtl/faded_sine_tone_sample.sv
// channel  | ports                                           | accepted when
// ---------+-------------------------------------------------+----------------------
// input    | in_push, in_full, in_frame_index,               | in_push && !in_full
//          | in_total_frames, in_tone_step                   |
// result   | out_empty, out_pop, out_pcm_sample              | out_pop && !out_empty
//
// one item per clock sustained while the result side keeps taking results; a result
// shows on the result ports once it has passed both pipes and both queues; its path is
// set mostly by the sixteen-stage restoring divider that forms the fade envelope
// reset is synchronous on rst_n low and empties both queues and all stages
// a stalled result side fills the output queue, then halts the back pipe, then
// the middle queue, then the front pipe; in_full follows that pressure
module faded_sine_tone_sample #(
  parameter int FRAME_BITS      = 20,
  parameter int PHASE_BITS      = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [FRAME_BITS-1:0]          in_frame_index,
  input  logic [FRAME_BITS-1:0]          in_total_frames,
  input  logic [fst_pkg::STEP_BITS-1:0]  in_tone_step,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic signed [fst_pkg::SAMPLE_BITS-1:0] out_pcm_sample
);

  import fst_pkg::*;

  localparam int ITEM_BITS = $bits(fst_item_t);

  // front to middle queue
  logic                   front_push;
  fst_item_t              front_item;
  logic                   mid_full;

  // middle queue to back
  logic                   mid_empty;
  logic                   mid_pop;
  logic [ITEM_BITS-1:0]   mid_dout;
  fst_item_t              mid_item;

  // back to output queue
  logic                   res_push;
  logic [SAMPLE_BITS-1:0] res_data;
  logic                   res_full;
  logic [SAMPLE_BITS-1:0] out_dout;

  assign mid_item       = fst_item_t'(mid_dout);
  assign out_pcm_sample = $signed(out_dout);

  // phase product, end-of-tone and ramp classification, sine table read
  fst_front #(
    .FRAME_BITS      (FRAME_BITS),
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .frame_index  (in_frame_index),
    .total_frames (in_total_frames),
    .tone_step    (in_tone_step),
    .item_push    (front_push),
    .item         (front_item),
    .item_full    (mid_full)
  );

  // short queue so front and back stall independently
  fst_fifo #(
    .WIDTH (ITEM_BITS),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_push),
    .din   (front_item),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty)
  );

  // envelope division, gain and envelope products, sign
  fst_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_empty (mid_empty),
    .item_pop   (mid_pop),
    .item       (mid_item),
    .out_push   (res_push),
    .out_data   (res_data),
    .out_full   (res_full)
  );

  // result queue, head item is shown on the result ports
  fst_fifo #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_dout),
    .empty (out_empty)
  );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  import fst_pkg::*;

  localparam int FRAME_BITS    = 20;
  localparam int QUARTER_STEPS = 256;          // quarter-wave table steps for a 10-bit index
  localparam int QUARTER_TURN  = 16384;        // tone step of a quarter turn per frame
  localparam int FRAME_MAX     = (1 << FRAME_BITS) - 1;
  localparam int STEP_MAX      = (1 << STEP_BITS) - 1;
  localparam int DRAIN_CYCLES  = 40;           // well past the result latency

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic                  in_push         = 1'b0;
  logic                  in_full;
  logic [FRAME_BITS-1:0] in_frame_index  = '0;
  logic [FRAME_BITS-1:0] in_total_frames = '0;
  logic [STEP_BITS-1:0]  in_tone_step    = '0;

  // result channel
  logic                          out_empty;
  logic                          out_pop = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_pcm_sample;

  // idling, in percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;

  // predicted samples still to come, oldest first
  logic signed [SAMPLE_BITS-1:0] expected_samples[$];
  logic signed [SAMPLE_BITS-1:0] wanted_sample;
  int unsigned                   error_count = 0;

  // our own quarter-wave sine table, q1.15
  logic [SINE_BITS-1:0] quarter_wave [0:QUARTER_STEPS];

  faded_sine_tone_sample uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_frame_index  (in_frame_index),
    .in_total_frames (in_total_frames),
    .in_tone_step    (in_tone_step),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pcm_sample  (out_pcm_sample)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sin(pi/2 * k / steps) from an odd taylor series in q30, each term truncated,
  // rounded to q1.15 and held below full scale
  function automatic logic [SINE_BITS-1:0] table_sine(input int unsigned k);
    longint unsigned angle;
    longint unsigned angle_sq;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned order;
    int              i;
    angle    = (HALF_PI_Q30 * longint'(k)) / QUARTER_STEPS;
    angle_sq = (angle * angle) >> 30;
    term     = angle;
    acc      = angle;
    order    = 1;
    for (i = 0; i < 8; i++) begin
      term  = ((term * angle_sq) >> 30) / ((order + 1) * (order + 2));
      order = order + 2;
      // alternate signs, never below zero
      if (i % 2 == 0) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    acc = (acc + 64'd16384) >> 15;
    if (acc > 64'd32767) begin
      acc = 64'd32767;
    end
    return acc[SINE_BITS-1:0];
  endfunction

  // expected pcm value of one frame of the faded tone
  function automatic logic signed [SAMPLE_BITS-1:0] tone_sample_of(
    input logic [FRAME_BITS-1:0] frame,
    input logic [FRAME_BITS-1:0] total,
    input logic [STEP_BITS-1:0]  step
  );
    logic [63:0]                   phase;
    logic [9:0]                    table_idx;
    logic [SINE_BITS-1:0]          sine;
    logic [63:0]                   fade_len;
    logic [63:0]                   env;
    logic [63:0]                   mag;
    logic                          unity;
    logic signed [SAMPLE_BITS-1:0] pcm;
    // at or past the end of the tone, zero-length tone included
    if (frame >= total) begin
      return '0;
    end
    // phase wraps at one turn, top ten bits address the table
    phase     = (64'(frame) * 64'(step)) & 64'hFFFF;
    table_idx = phase[15:6];
    // odd quadrants run the table backwards, upper half is negative
    if (table_idx[8]) begin
      sine = quarter_wave[QUARTER_STEPS - int'(table_idx[7:0])];
    end else begin
      sine = quarter_wave[table_idx[7:0]];
    end
    // fade length is an eighth of the tone, capped at 10 ms
    fade_len = 64'(total) / 8;
    if (fade_len > FADE_CAP) begin
      fade_len = FADE_CAP;
    end
    unity = 1'b1;
    env   = '0;
    if (fade_len != 0) begin
      if (64'(frame) > 64'(total) - fade_len) begin
        // falling edge of the fade
        env   = ((64'(total) - 64'(frame)) << 16) / fade_len;
        unity = 1'b0;
      end else if (64'(frame) < fade_len) begin
        // rising edge of the fade
        env   = (64'(frame) << 16) / fade_len;
        unity = 1'b0;
      end
    end
    // magnitude first, sign afterwards, so truncation is towards zero
    mag = 64'(sine) * TONE_GAIN;
    if (unity) begin
      mag = mag >> 15;
    end else begin
      mag = (mag * env) >> 31;
    end
    pcm = mag[SAMPLE_BITS-1:0];
    if (table_idx[9]) begin
      pcm = -pcm;
    end
    return pcm;
  endfunction

  // offer one item from a falling edge, wait for it to be taken, and note the
  // expected sample; push stays high on return so back-to-back items need no gap
  task automatic send_frame(
    input logic [FRAME_BITS-1:0] frame,
    input logic [FRAME_BITS-1:0] total,
    input logic [STEP_BITS-1:0]  step
  );
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push         <= 1'b1;
    in_frame_index  <= frame;
    in_total_frames <= total;
    in_tone_step    <= step;
    @(posedge clk);
    while (in_full) begin
      @(posedge clk);
    end
    expected_samples.push_back(tone_sample_of(frame, total, step));
    @(negedge clk);
  endtask

  // extremes of the fields and every special case of the envelope and quadrants
  task automatic test_edge_cases();
    // zero-length tone and frames at or past the end
    send_frame(0, 0, 0);
    send_frame(FRAME_MAX, FRAME_MAX, STEP_MAX);
    send_frame(1000, 500, QUARTER_TURN);
    send_frame(FRAME_MAX, 0, STEP_MAX);
    // first frame of a long tone, envelope at zero
    send_frame(0, FRAME_MAX, STEP_MAX);
    // zero step gives zero phase
    send_frame(5000, 100000, 0);
    // short tone without fade, at the sine peak and at a zero
    send_frame(1, 7, QUARTER_TURN);
    send_frame(6, 7, QUARTER_TURN);
    // shortest tone with a fade of one frame
    send_frame(0, 8, QUARTER_TURN);
    send_frame(5, 8, QUARTER_TURN);
    send_frame(7, 8, QUARTER_TURN);
    // fade exactly at the cap and just below it
    send_frame(81, 1280, QUARTER_TURN);
    send_frame(1279, 1280, 3 * QUARTER_TURN / 2 - 1);
    send_frame(79, 1279, QUARTER_TURN);
    send_frame(1200, 1279, QUARTER_TURN);
    // all four quadrants in the steady part
    send_frame(200, 10000, QUARTER_TURN);
    send_frame(201, 10000, QUARTER_TURN);
    send_frame(202, 10000, QUARTER_TURN);
    send_frame(203, 10000, QUARTER_TURN);
    // odd table positions in the second and fourth quadrants
    send_frame(300, 10000, 4097);
    send_frame(301, 10000, 21003);
    send_frame(302, 10000, 32001);
    // last frames of the longest tone
    send_frame(FRAME_MAX - 1, FRAME_MAX, STEP_MAX);
    send_frame(FRAME_MAX - 161, FRAME_MAX, 12345);
  endtask

  // whole tones: a length and a step, then runs of frames near the start,
  // near the end and in the middle
  task automatic test_tone_bursts(input int unsigned tone_count);
    int unsigned n;
    int unsigned run;
    int unsigned j;
    int          total;
    int          fade_len;
    int          anchor;
    logic [STEP_BITS-1:0] step;
    for (n = 0; n < tone_count; n++) begin
      case ($urandom_range(4, 0))
        0, 1: total = $urandom_range(40, 1);
        2, 3: total = $urandom_range(4000, 41);
        default: total = $urandom_range(FRAME_MAX, 4001);
      endcase
      step     = $urandom_range(STEP_MAX, 0);
      fade_len = (total / 8 > FADE_CAP) ? FADE_CAP : total / 8;
      for (run = 0; run < 4; run++) begin
        case ($urandom_range(2, 0))
          0: anchor = $urandom_range(fade_len + 2, 0);
          1: anchor = total - 1 - int'($urandom_range(fade_len + 2, 0));
          default: anchor = $urandom_range(total - 1, 0);
        endcase
        if (anchor < 0) begin
          anchor = 0;
        end
        // a run may step past the last frame, which is legal
        for (j = 0; j < 4; j++) begin
          send_frame(anchor + j, total, step);
        end
      end
    end
  endtask

  // fields drawn over their whole range, so about half fall past the end
  task automatic test_random_fields(input int unsigned item_count);
    int unsigned n;
    for (n = 0; n < item_count; n++) begin
      send_frame($urandom_range(FRAME_MAX, 0), $urandom_range(FRAME_MAX, 0),
                 $urandom_range(STEP_MAX, 0));
    end
  endtask

  // receiver: pop decided at the falling edge
  always @(negedge clk) begin
    out_pop <= rst_n && ($urandom_range(99, 0) >= pop_stall_pct);
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_samples.size() == 0) begin
        $error("pcm_sample: item with nothing expected, actual %0d", out_pcm_sample);
        error_count++;
      end else begin
        wanted_sample = expected_samples.pop_front();
        if (out_pcm_sample !== wanted_sample) begin
          $error("pcm_sample: expected %0d, actual %0d", wanted_sample, out_pcm_sample);
          error_count++;
        end
      end
    end
  end

  // idling phases: none, sender only, receiver only, both
  initial begin
    int unsigned phase_no;
    for (int unsigned k = 0; k <= QUARTER_STEPS; k++) begin
      quarter_wave[k] = table_sine(k);
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_edge_cases();
    for (phase_no = 0; phase_no < 4; phase_no++) begin
      send_idle_pct = (phase_no == 1) ? 56 : (phase_no == 3) ? 36 : 0;
      pop_stall_pct = (phase_no == 2) ? 56 : (phase_no == 3) ? 36 : 0;
      test_tone_bursts(15);
      test_random_fields(60);
    end
    in_push <= 1'b0;
    // drain, then give stray items a chance to show
    while (expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
